>>> rtl/core/ihss_pkg.sv
// shared types and constants for the image header size sniffer
// used by the front classifier, the item queue, the parser and the top level
`timescale 1ns / 1ps
`default_nettype none

package ihss_pkg;

  localparam int unsigned DimW = 32;

  // image_format codes
  localparam logic [1:0] FMT_BMP  = 2'd0;
  localparam logic [1:0] FMT_PNG  = 2'd1;
  localparam logic [1:0] FMT_JPEG = 2'd2;

  // result status codes
  localparam logic [1:0] ST_FOUND   = 2'd0;
  localparam logic [1:0] ST_BAD_SIG = 2'd1;
  localparam logic [1:0] ST_NO_SIZE = 2'd2;

  localparam logic [0:7][7:0] PNG_SIG  = {8'd137, 8'd80, 8'd78, 8'd71,
                                          8'd13, 8'd10, 8'd26, 8'd10};
  localparam logic [0:3][7:0] IHDR_TAG = {8'h49, 8'h48, 8'h44, 8'h52};

  localparam logic [7:0] JPG_FF   = 8'hFF;
  localparam logic [7:0] JPG_SOI  = 8'hD8;
  localparam logic [7:0] JPG_SOF0 = 8'hC0;
  localparam logic [7:0] JPG_SOF2 = 8'hC2;

  // one classified byte as it travels from front to parser
  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
    logic [1:0] fmt;
    logic       is_ff;
    logic       is_d8;
    logic       is_sof;
    logic [7:0] sig_hit;
    logic [3:0] ihdr_hit;
  } item_t;

endpackage

`default_nettype wire

>>> rtl/core/ihss_front.sv
// front stage: format register, byte classification and one item register
// depends on ihss_pkg
`timescale 1ns / 1ps
`default_nettype none

module ihss_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_wdata_i,
  input  logic          push_i,
  output logic          full_o,
  input  logic [7:0]    data_byte_i,
  input  logic          first_byte_i,
  input  logic          end_of_file_i,
  output logic          item_valid_o,
  output ihss_pkg::item_t item_o,
  input  logic          item_ready_i
);
  import ihss_pkg::*;

  logic [1:0] fmt_q;
  logic       valid_q, valid_d;
  item_t      item_q, item_d;

  always_comb begin
    item_d.data   = data_byte_i;
    item_d.first  = first_byte_i;
    item_d.last   = end_of_file_i;
    item_d.fmt    = fmt_q;
    item_d.is_ff  = (data_byte_i == JPG_FF);
    item_d.is_d8  = (data_byte_i == JPG_SOI);
    item_d.is_sof = (data_byte_i == JPG_SOF0) || (data_byte_i == JPG_SOF2);
    for (int i = 0; i < 8; i++) begin
      item_d.sig_hit[i] = (data_byte_i == PNG_SIG[i]);
    end
    for (int i = 0; i < 4; i++) begin
      item_d.ihdr_hit[i] = (data_byte_i == IHDR_TAG[i]);
    end
  end

  assign full_o  = valid_q && !item_ready_i;
  assign valid_d = full_o ? valid_q : push_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q   <= FMT_BMP;
      valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        fmt_q <= cfg_wdata_i;
      end
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      item_q <= item_d;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

`default_nettype wire

>>> rtl/core/ihss_fifo.sv
// short item queue between the front stage and the parser
// depends on ihss_pkg for the item type
`timescale 1ns / 1ps
`default_nettype none

module ihss_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_valid_i,
  output logic            wr_ready_o,
  input  ihss_pkg::item_t wr_item_i,
  output logic            rd_valid_o,
  input  logic            rd_take_i,
  output ihss_pkg::item_t rd_item_o
);
  import ihss_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  item_t           mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_wr, do_rd;

  assign wr_ready_o = (cnt_q != FullCnt);
  assign rd_valid_o = (cnt_q != '0);
  assign rd_item_o  = mem_q[rd_ptr_q];
  assign do_wr      = wr_valid_i && wr_ready_o;
  assign do_rd      = rd_take_i && rd_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_item_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/ihss_parser.sv
// back end: header parse state machine and the result register
// depends on ihss_pkg
`timescale 1ns / 1ps
`default_nettype none

module ihss_parser (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    item_valid_i,
  input  ihss_pkg::item_t         item_i,
  output logic                    item_take_o,
  output logic                    res_valid_o,
  input  logic                    res_pop_i,
  output logic signed [31:0]      res_width_o,
  output logic signed [31:0]      res_height_o,
  output logic [1:0]              res_status_o
);
  import ihss_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE, PH_DONE, PH_BMP, PH_PNG_SIG, PH_PNG_LEN, PH_PNG_TYPE, PH_PNG_SKIP,
    PH_PNG_CRC, PH_PNG_W, PH_PNG_H, PH_JPG_SIG, PH_JPG_SCAN, PH_JPG_MARK,
    PH_JPG_LEN, PH_JPG_SKIP, PH_JPG_SOF
  } phase_e;

  phase_e          phase_q, phase_d;
  logic [DimW-1:0] cnt_q, cnt_d, shift_q, shift_d, held_q, held_d;
  logic            hdr_q, hdr_d;
  logic            res_valid_q;
  logic [DimW-1:0] res_w_q, res_h_q;
  logic [1:0]      res_st_q;

  logic            emit;
  logic            no_byte;
  logic [DimW-1:0] emit_w, emit_h;
  logic [1:0]      emit_st;
  logic [DimW-1:0] cnt_inc;
  logic [1:0]      lane;
  logic [15:0]     seg_len, seg_skip;

  assign item_take_o = item_valid_i && (!res_valid_q || res_pop_i);

  always_comb begin
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    shift_d  = shift_q;
    held_d   = held_q;
    hdr_d    = hdr_q;
    emit     = 1'b0;
    no_byte  = 1'b0;
    emit_w   = '0;
    emit_h   = '0;
    emit_st  = ST_FOUND;
    cnt_inc  = '0;
    lane     = '0;
    seg_len  = '0;
    seg_skip = '0;

    if (item_i.first) begin
      cnt_d   = '0;
      shift_d = '0;
      held_d  = '0;
      hdr_d   = 1'b0;
      case (item_i.fmt)
        FMT_BMP:  phase_d = PH_BMP;
        FMT_PNG:  phase_d = PH_PNG_SIG;
        FMT_JPEG: phase_d = PH_JPG_SIG;
        default: begin
          emit    = 1'b1;
          emit_st = ST_BAD_SIG;
          phase_d = PH_DONE;
          no_byte = 1'b1;
        end
      endcase
    end

    cnt_inc = cnt_d + 1'b1;

    if (!no_byte) begin
      case (phase_d)
        PH_BMP: begin
          if (cnt_d >= 32'd18 && cnt_d <= 32'd25) begin
            // byte lane inside the current 32-bit little-endian field
            lane = cnt_d[1:0] + 2'd2;
            if (cnt_d == 32'd18 || cnt_d == 32'd22) begin
              shift_d = '0;
            end
            shift_d[{lane, 3'b000} +: 8] = item_i.data;
            if (cnt_d == 32'd21) begin
              held_d = shift_d;
            end
            if (cnt_d == 32'd25) begin
              emit   = 1'b1;
              emit_w = held_d;
              emit_h = shift_d;
            end
          end
          if (cnt_d < 32'd26) begin
            cnt_d = cnt_inc;
          end
        end
        PH_PNG_SIG: begin
          if (!item_i.sig_hit[cnt_d[2:0]]) begin
            emit    = 1'b1;
            emit_st = ST_BAD_SIG;
          end else if (cnt_d >= 32'd7) begin
            phase_d = PH_PNG_LEN;
            cnt_d   = '0;
            shift_d = '0;
          end else begin
            cnt_d = cnt_inc;
          end
        end
        PH_PNG_LEN: begin
          shift_d = {shift_d[23:0], item_i.data};
          cnt_d   = cnt_inc;
          if (cnt_inc >= 32'd4) begin
            phase_d = PH_PNG_TYPE;
            cnt_d   = '0;
            hdr_d   = 1'b1;
          end
        end
        PH_PNG_TYPE: begin
          if (!item_i.ihdr_hit[cnt_d[1:0]]) begin
            hdr_d = 1'b0;
          end
          cnt_d = cnt_inc;
          if (cnt_inc >= 32'd4) begin
            if (hdr_d) begin
              phase_d = PH_PNG_W;
              cnt_d   = '0;
              shift_d = '0;
            end else if (shift_d == '0) begin
              phase_d = PH_PNG_CRC;
              cnt_d   = '0;
            end else begin
              phase_d = PH_PNG_SKIP;
              cnt_d   = shift_d;
            end
          end
        end
        PH_PNG_SKIP, PH_JPG_SKIP: begin
          if (cnt_d != '0) begin
            cnt_d = cnt_d - 1'b1;
          end
          if (cnt_d == '0) begin
            phase_d = (phase_d == PH_PNG_SKIP) ? PH_PNG_CRC : PH_JPG_SCAN;
          end
        end
        PH_PNG_CRC: begin
          cnt_d = cnt_inc;
          if (cnt_inc >= 32'd4) begin
            phase_d = PH_PNG_LEN;
            cnt_d   = '0;
            shift_d = '0;
          end
        end
        PH_PNG_W: begin
          shift_d = {shift_d[23:0], item_i.data};
          cnt_d   = cnt_inc;
          if (cnt_inc >= 32'd4) begin
            held_d  = shift_d;
            phase_d = PH_PNG_H;
            cnt_d   = '0;
            shift_d = '0;
          end
        end
        PH_PNG_H: begin
          shift_d = {shift_d[23:0], item_i.data};
          cnt_d   = cnt_inc;
          if (cnt_inc >= 32'd4) begin
            emit   = 1'b1;
            emit_w = held_d;
            emit_h = shift_d;
          end
        end
        PH_JPG_SIG: begin
          if ((cnt_d == '0) ? !item_i.is_ff : !item_i.is_d8) begin
            emit    = 1'b1;
            emit_st = ST_BAD_SIG;
          end else if (cnt_d >= 32'd1) begin
            phase_d = PH_JPG_SCAN;
          end else begin
            cnt_d = cnt_inc;
          end
        end
        PH_JPG_SCAN: begin
          if (item_i.is_ff) begin
            phase_d = PH_JPG_MARK;
          end
        end
        PH_JPG_MARK: begin
          cnt_d   = '0;
          shift_d = '0;
          phase_d = item_i.is_sof ? PH_JPG_SOF : PH_JPG_LEN;
        end
        PH_JPG_LEN: begin
          seg_len = {shift_d[7:0], item_i.data};
          shift_d = {16'd0, seg_len};
          cnt_d   = cnt_inc;
          if (cnt_inc >= 32'd2) begin
            seg_skip = (seg_len >= 16'd2) ? seg_len - 16'd2 : 16'd0;
            if (seg_skip == '0) begin
              phase_d = PH_JPG_SCAN;
            end else begin
              phase_d = PH_JPG_SKIP;
              cnt_d   = {16'd0, seg_skip};
            end
          end
        end
        PH_JPG_SOF: begin
          // three bytes of precision and length, then height and width
          if (cnt_d >= 32'd3) begin
            shift_d = {shift_d[23:0], item_i.data};
          end
          cnt_d = cnt_inc;
          if (cnt_inc >= 32'd7) begin
            emit   = 1'b1;
            emit_w = {16'd0, shift_d[15:0]};
            emit_h = {16'd0, shift_d[31:16]};
          end
        end
        default: begin
        end
      endcase

      if (!emit && item_i.last && phase_d != PH_IDLE && phase_d != PH_DONE) begin
        emit    = 1'b1;
        emit_st = ST_NO_SIZE;
      end
    end

    if (emit) begin
      phase_d = PH_DONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      cnt_q       <= '0;
      shift_q     <= '0;
      held_q      <= '0;
      hdr_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (item_take_o) begin
        phase_q <= phase_d;
        cnt_q   <= cnt_d;
        shift_q <= shift_d;
        held_q  <= held_d;
        hdr_q   <= hdr_d;
      end
      if (item_take_o && emit) begin
        res_valid_q <= 1'b1;
      end else if (res_pop_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_take_o && emit) begin
      res_w_q  <= emit_w;
      res_h_q  <= emit_h;
      res_st_q <= emit_st;
    end
  end

  assign res_valid_o  = res_valid_q;
  assign res_width_o  = res_w_q;
  assign res_height_o = res_h_q;
  assign res_status_o = res_st_q;

endmodule

`default_nettype wire

>>> rtl/core/image_header_size_sniffer.sv
// image header size sniffer: one file byte per cycle while full is low, at most one result per file
// a result reaches the outputs through the front register, then the queue, then the parser
// result register; throughput is one byte per cycle, the parser taking one queued byte
// each cycle while its result register is free
// reset (asynchronous, active low) empties the front register, the queue and the result
// register, sets format to bmp and parks the parser waiting for a first byte
`timescale 1ns / 1ps
`default_nettype none

module image_header_size_sniffer #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_wdata_i,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         data_byte_i,
  input  logic               first_byte_i,
  input  logic               end_of_file_i,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] image_width_o,
  output logic signed [31:0] image_height_o,
  output logic [1:0]         status_o
);
  import ihss_pkg::*;

  logic  front_valid, front_ready;
  item_t front_item;
  logic  q_valid, q_take;
  item_t q_item;
  logic  res_valid;

  ihss_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .push_i        (push),
    .full_o        (full),
    .data_byte_i   (data_byte_i),
    .first_byte_i  (first_byte_i),
    .end_of_file_i (end_of_file_i),
    .item_valid_o  (front_valid),
    .item_o        (front_item),
    .item_ready_i  (front_ready)
  );

  ihss_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (front_valid),
    .wr_ready_o (front_ready),
    .wr_item_i  (front_item),
    .rd_valid_o (q_valid),
    .rd_take_i  (q_take),
    .rd_item_o  (q_item)
  );

  ihss_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (q_valid),
    .item_i       (q_item),
    .item_take_o  (q_take),
    .res_valid_o  (res_valid),
    .res_pop_i    (pop),
    .res_width_o  (image_width_o),
    .res_height_o (image_height_o),
    .res_status_o (status_o)
  );

  assign empty = !res_valid;

`ifndef SYNTHESIS
  // the parser never takes a byte while an unpopped result blocks it
  a_take_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_take |-> (empty || pop))
    else $error("parser took an item with result register occupied");

  // a new result only appears after the parser took a byte
  a_result_from_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(empty) |-> $past(q_take))
    else $error("result appeared without a parsed item");

  // status is one of the three defined codes
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (status_o == ST_FOUND || status_o == ST_BAD_SIG || status_o == ST_NO_SIZE))
    else $error("undefined status code");

  // error results carry a zero size
  a_error_zero_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o != ST_FOUND) |-> (image_width_o == 0 && image_height_o == 0))
    else $error("error result with nonzero size");
`endif

endmodule

`default_nettype wire
